@@ rtl/core/lkvc_pkg.sv @@
// Shared types and constants of the LRU key-value cache.
package lkvc_pkg;

  localparam int unsigned DEF_ENTRIES = 16;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned CAP_W       = 5;
  localparam int unsigned ADDR_W      = 3;
  localparam int unsigned PDATA_W     = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic [ADDR_W-3:0] REG_CAPACITY = 1'b0;

  typedef enum logic {
    KIND_GET = 1'b0,
    KIND_PUT = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP,
    ST_UPDATE
  } state_e;

endpackage

@@ rtl/core/lru_key_value_cache_top.sv @@
// Top level of the LRU key-value cache.
//
// Usage: drive kind_i/key_i/value_i and raise start while busy is low; the
// item is taken at that edge. kind_i = get looks the key up, put inserts or
// updates it. Exactly one result per item: done_o is high for one cycle with
// hit_o (key was present before the item) and read_value_o (stored value on a
// get hit, else 0). The receiver cannot hold results off.
// Each entry (key, value, recency rank) lives in one RAM; valid bits are flops.
// An item makes one read sweep over all ENTRIES rows (key compare, victim and
// free-slot search), then, except for a get miss, one read-modify-write sweep
// (rank aging, eviction, insert). The single RAM read port sets the rate:
// done_o rises once the read sweep ends, and busy stays high until the last
// sweep ends, so a new item is taken only after the last one is through.
// capacity_in_use sits at byte 0 of the APB port (0 acts as 1, values above
// ENTRIES saturate); write it only while busy is low. Lowering it evicts
// nothing until the next put of a new key.
// Reset empties the cache and sets capacity_in_use to 16; no clearing pass.
module lru_key_value_cache_top #(
  parameter int unsigned ENTRIES = lkvc_pkg::DEF_ENTRIES
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic                              kind_i,
  input  logic signed [lkvc_pkg::DATA_W-1:0] key_i,
  input  logic signed [lkvc_pkg::DATA_W-1:0] value_i,
  output logic                              done_o,
  output logic                              hit_o,
  output logic signed [lkvc_pkg::DATA_W-1:0] read_value_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lkvc_pkg::ADDR_W-1:0]       paddr,
  input  logic [lkvc_pkg::PDATA_W-1:0]      pwdata,
  output logic [lkvc_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready
);

  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned RW = AW;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned WW = (CW > lkvc_pkg::CAP_W) ? CW : lkvc_pkg::CAP_W;
  localparam int unsigned DW = lkvc_pkg::DATA_W;
  localparam int unsigned MW = 2 * DW + RW;

  lkvc_pkg::state_e state_q, state_d;
  lkvc_pkg::kind_e  kind_q, kind_d;

  logic [lkvc_pkg::CAP_W-1:0] cap_q, cap_d;
  logic [CW-1:0]              count_q, count_d;
  logic [ENTRIES-1:0]         valid_q, valid_d;
  logic [AW:0]                cnt_q, cnt_d;
  logic                       pv_q, pv_d;
  logic [AW-1:0]              pidx_q, pidx_d;
  logic                       hit_q, hit_d;
  logic                       slot_found_q, slot_found_d;

  logic [DW-1:0] key_q, key_d;
  logic [DW-1:0] val_in_q, val_in_d;
  logic [DW-1:0] hval_q, hval_d;
  logic [AW-1:0] hidx_q, hidx_d;
  logic [RW-1:0] hrank_q, hrank_d;
  logic [AW-1:0] slot_q, slot_d;

  logic          accept;
  logic          last;
  logic          ram_re, ram_we;
  logic [MW-1:0] ram_rdata, ram_wdata;
  logic [DW-1:0] rd_key, rd_val, w_key, w_val;
  logic [RW-1:0] rd_rank, w_rank;
  logic          cur_valid;
  logic [WW-1:0] cap_w, eff_w;
  logic [CW-1:0] eff, lim;
  logic          evict;
  logic          old_rank;
  logic          cfg_wr;

  assign accept = start && !busy;
  assign last   = (cnt_q == (AW + 1)'(ENTRIES));

  // effective capacity and eviction threshold
  always_comb begin
    cap_w = WW'(cap_q);
    if (cap_w == '0) begin
      eff_w = WW'(1);
    end else if (cap_w > WW'(ENTRIES)) begin
      eff_w = WW'(ENTRIES);
    end else begin
      eff_w = cap_w;
    end
    eff = CW'(eff_w);
    lim = eff - CW'(1);
  end

  assign evict = (count_q >= eff);

  assign rd_key    = ram_rdata[MW-1 -: DW];
  assign rd_val    = ram_rdata[RW +: DW];
  assign rd_rank   = ram_rdata[RW-1:0];
  assign cur_valid = valid_q[pidx_q];
  assign old_rank  = (CW'(rd_rank) >= lim);
  assign ram_wdata = {w_key, w_val, w_rank};

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite &&
                  (paddr[lkvc_pkg::ADDR_W-1:2] == lkvc_pkg::REG_CAPACITY);
  assign cap_d  = cfg_wr ? pwdata[lkvc_pkg::CAP_W-1:0] : cap_q;

  always_comb begin
    prdata = '0;
    if (paddr[lkvc_pkg::ADDR_W-1:2] == lkvc_pkg::REG_CAPACITY) begin
      prdata = lkvc_pkg::PDATA_W'(cap_q);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lkvc_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = lkvc_pkg::ST_SCAN;
        end
      end
      lkvc_pkg::ST_SCAN: begin
        if (last) begin
          state_d = lkvc_pkg::ST_RESP;
        end
      end
      lkvc_pkg::ST_RESP: begin
        if (hit_q || (kind_q == lkvc_pkg::KIND_PUT)) begin
          state_d = lkvc_pkg::ST_UPDATE;
        end else begin
          state_d = lkvc_pkg::ST_IDLE;
        end
      end
      lkvc_pkg::ST_UPDATE: begin
        if (last) begin
          state_d = lkvc_pkg::ST_IDLE;
        end
      end
      default: state_d = lkvc_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    busy   = 1'b1;
    done_o = 1'b0;
    ram_re = 1'b0;
    ram_we = 1'b0;
    unique case (state_q)
      lkvc_pkg::ST_IDLE: begin
        busy = 1'b0;
      end
      lkvc_pkg::ST_SCAN: begin
        ram_re = !last;
      end
      lkvc_pkg::ST_RESP: begin
        done_o = 1'b1;
      end
      lkvc_pkg::ST_UPDATE: begin
        ram_re = !last;
        ram_we = pv_q;
      end
      default: busy = 1'b1;
    endcase
  end

  assign hit_o        = hit_q;
  assign read_value_o = (hit_q && (kind_q == lkvc_pkg::KIND_GET)) ? $signed(hval_q) : '0;

  // sweep datapath
  always_comb begin
    kind_d       = kind_q;
    key_d        = key_q;
    val_in_d     = val_in_q;
    count_d      = count_q;
    valid_d      = valid_q;
    cnt_d        = cnt_q;
    pv_d         = 1'b0;
    pidx_d       = pidx_q;
    hit_d        = hit_q;
    hval_d       = hval_q;
    hidx_d       = hidx_q;
    hrank_d      = hrank_q;
    slot_found_d = slot_found_q;
    slot_d       = slot_q;
    w_key        = rd_key;
    w_val        = rd_val;
    w_rank       = rd_rank;

    if (ram_re) begin
      cnt_d  = cnt_q + (AW + 1)'(1);
      pv_d   = 1'b1;
      pidx_d = cnt_q[AW-1:0];
    end

    unique case (state_q)
      lkvc_pkg::ST_IDLE: begin
        if (accept) begin
          kind_d       = lkvc_pkg::kind_e'(kind_i);
          key_d        = $unsigned(key_i);
          val_in_d     = $unsigned(value_i);
          cnt_d        = '0;
          hit_d        = 1'b0;
          slot_found_d = 1'b0;
        end
      end
      lkvc_pkg::ST_SCAN: begin
        if (pv_q) begin
          if (cur_valid && (rd_key == key_q) && !hit_q) begin
            hit_d   = 1'b1;
            hidx_d  = pidx_q;
            hrank_d = rd_rank;
            hval_d  = rd_val;
          end
          if (!slot_found_q && (!cur_valid || (evict && old_rank))) begin
            slot_found_d = 1'b1;
            slot_d       = pidx_q;
          end
        end
      end
      lkvc_pkg::ST_RESP: begin
        cnt_d = '0;
      end
      lkvc_pkg::ST_UPDATE: begin
        if (pv_q) begin
          if (hit_q) begin
            if (pidx_q == hidx_q) begin
              w_rank = '0;
              if (kind_q == lkvc_pkg::KIND_PUT) begin
                w_val = val_in_q;
              end
            end else if (cur_valid && (rd_rank < hrank_q)) begin
              w_rank = rd_rank + RW'(1);
            end
          end else begin
            if (pidx_q == slot_q) begin
              w_key           = key_q;
              w_val           = val_in_q;
              w_rank          = '0;
              valid_d[pidx_q] = 1'b1;
            end else if (cur_valid) begin
              if (evict && old_rank) begin
                valid_d[pidx_q] = 1'b0;
              end else begin
                w_rank = rd_rank + RW'(1);
              end
            end
          end
        end
        if (last && !hit_q) begin
          count_d = evict ? eff : count_q + CW'(1);
        end
      end
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= lkvc_pkg::ST_IDLE;
      kind_q       <= lkvc_pkg::KIND_GET;
      cap_q        <= lkvc_pkg::CAP_RESET;
      count_q      <= '0;
      valid_q      <= '0;
      cnt_q        <= '0;
      pv_q         <= 1'b0;
      hit_q        <= 1'b0;
      slot_found_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      kind_q       <= kind_d;
      cap_q        <= cap_d;
      count_q      <= count_d;
      valid_q      <= valid_d;
      cnt_q        <= cnt_d;
      pv_q         <= pv_d;
      hit_q        <= hit_d;
      slot_found_q <= slot_found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    val_in_q <= val_in_d;
    pidx_q   <= pidx_d;
    hval_q   <= hval_d;
    hidx_q   <= hidx_d;
    hrank_q  <= hrank_d;
    slot_q   <= slot_d;
  end

  lkvc_ram #(
    .WIDTH(MW),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(pidx_q),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(cnt_q[AW-1:0]),
    .rdata_o(ram_rdata)
  );

endmodule

@@ rtl/core/lkvc_ram.sv @@
// Generic simple dual-port RAM with registered read.
module lkvc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/lkvc_checker.sv @@
// Port-level checker of the LRU key-value cache and its bind.
module lkvc_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start,
  input logic                              busy,
  input logic                              done_o,
  input logic                              hit_o,
  input logic signed [lkvc_pkg::DATA_W-1:0] read_value_o
);

  logic accept;
  assign accept = start && !busy;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("busy low after item accepted");

  a_done_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result outside busy window");

  a_single_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_no_early_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !done_o)
    else $error("result right after accept");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !hit_o) |-> (read_value_o == '0))
    else $error("nonzero read value on miss");

endmodule

bind lru_key_value_cache_top lkvc_checker u_lkvc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .done_o      (done_o),
  .hit_o       (hit_o),
  .read_value_o(read_value_o)
);

@@ tb/lru_key_value_cache_checker.sv @@
// Checker for the LRU key-value cache: tracks config, predicts each item's result and compares.
module lru_key_value_cache_checker #(
  parameter int unsigned ENTRIES = lkvc_pkg::DEF_ENTRIES
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          busy_i,
  input  logic                          kind_i,
  input  logic [lkvc_pkg::DATA_W-1:0]   key_i,
  input  logic [lkvc_pkg::DATA_W-1:0]   value_i,
  input  logic                          done_i,
  input  logic                          hit_i,
  input  logic [lkvc_pkg::DATA_W-1:0]   read_value_i,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [lkvc_pkg::ADDR_W-1:0]   paddr_i,
  input  logic [lkvc_pkg::PDATA_W-1:0]  pwdata_i,
  input  logic [lkvc_pkg::PDATA_W-1:0]  prdata_i,
  input  logic                          pready_i,
  output int                            outstanding_o,
  output int                            fail_count_o
);
  import lkvc_pkg::*;

  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] read_value;
  } lookup_t;

  logic [DATA_W-1:0] slot_key   [ENTRIES];
  logic [DATA_W-1:0] slot_value [ENTRIES];
  logic              slot_valid [ENTRIES];
  int unsigned       slot_rank  [ENTRIES];
  int unsigned       fill;
  logic [CAP_W-1:0]  cap_reg;
  lookup_t           lookup_q [$];
  int                mismatches = 0;

  assign fail_count_o = mismatches;

  function automatic int unsigned cap_limit();
    if (cap_reg == '0) return 1;
    if (cap_reg > ENTRIES) return ENTRIES;
    return cap_reg;
  endfunction

  function automatic int find_slot(logic [DATA_W-1:0] key);
    for (int i = 0; i < ENTRIES; i++)
      if (slot_valid[i] && slot_key[i] == key) return i;
    return -1;
  endfunction

  // entries more recent than idx age by one, idx becomes most recent
  function automatic void promote(int idx);
    int unsigned r;
    r = slot_rank[idx];
    for (int i = 0; i < ENTRIES; i++)
      if (slot_valid[i] && i != idx && slot_rank[i] < r) slot_rank[i] += 1;
    slot_rank[idx] = 0;
  endfunction

  function automatic void drop_oldest();
    int victim;
    victim = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (slot_valid[i] && (victim < 0 || slot_rank[i] > slot_rank[victim])) victim = i;
    if (victim < 0) begin
      fill = 0;
      return;
    end
    slot_valid[victim] = 1'b0;
    slot_rank[victim]  = 0;
    if (fill > 0) fill -= 1;
  endfunction

  function automatic void insert_entry(logic [DATA_W-1:0] key, logic [DATA_W-1:0] value);
    int free_idx;
    free_idx = -1;
    while (fill >= cap_limit() && fill > 0) drop_oldest();
    for (int i = ENTRIES - 1; i >= 0; i--)
      if (!slot_valid[i]) free_idx = i;
    for (int i = 0; i < ENTRIES; i++)
      if (slot_valid[i]) slot_rank[i] += 1;
    slot_key[free_idx]   = key;
    slot_value[free_idx] = value;
    slot_valid[free_idx] = 1'b1;
    slot_rank[free_idx]  = 0;
    fill += 1;
  endfunction

  function automatic lookup_t apply_request(logic kind, logic [DATA_W-1:0] key,
                                            logic [DATA_W-1:0] value);
    lookup_t res;
    int      idx;
    idx = find_slot(key);
    res.hit = (idx >= 0);
    res.read_value = '0;
    if (kind == KIND_GET) begin
      if (idx >= 0) begin
        res.read_value = slot_value[idx];
        promote(idx);
      end
    end else if (idx >= 0) begin
      slot_value[idx] = value;
      promote(idx);
    end else begin
      insert_entry(key, value);
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lookup_t want;
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        slot_valid[i] = 1'b0;
        slot_rank[i]  = 0;
      end
      fill    = 0;
      cap_reg = CAP_RESET;
      lookup_q.delete();
      outstanding_o <= 0;
    end else begin
      if (done_i) begin
        if (lookup_q.size() == 0) begin
          $error("result with nothing outstanding: hit=%0b read_value=%h", hit_i, read_value_i);
          mismatches++;
        end else begin
          want = lookup_q.pop_front();
          if (hit_i !== want.hit) begin
            $error("hit: expected %0b, actual %0b", want.hit, hit_i);
            mismatches++;
          end
          if (read_value_i !== want.read_value) begin
            $error("read_value: expected %h, actual %h", want.read_value, read_value_i);
            mismatches++;
          end
        end
      end
      if (start_i && !busy_i) lookup_q.push_back(apply_request(kind_i, key_i, value_i));
      if (psel_i && penable_i && pready_i && paddr_i[ADDR_W-1:2] == REG_CAPACITY) begin
        if (pwrite_i) begin
          cap_reg = pwdata_i[CAP_W-1:0];
        end else if (prdata_i !== {{(PDATA_W-CAP_W){1'b0}}, cap_reg}) begin
          $error("capacity_in_use: expected %h, actual %h", cap_reg, prdata_i);
          mismatches++;
        end
      end
      outstanding_o <= lookup_q.size();
    end
  end

endmodule

@@ tb/tb_lru_key_value_cache_top.sv @@
// Testbench top for the LRU key-value cache: drives items and config, reports the verdict.
module tb_lru_key_value_cache_top;
  import lkvc_pkg::*;

  localparam int unsigned ENTRIES          = DEF_ENTRIES;
  localparam int unsigned CYCLE_LIMIT      = 400000;
  localparam int unsigned SETTLE_CYCLES    = 2 * ENTRIES + 8;
  localparam int unsigned ITEMS_PER_PHASE  = 90;
  localparam int unsigned POOL_SIZE        = 24;
  localparam logic [DATA_W-1:0] KEY_MIN    = 32'h8000_0000;
  localparam logic [DATA_W-1:0] KEY_MAX    = 32'h7fff_ffff;
  localparam logic [ADDR_W-1:0] CAP_ADDR   = {REG_CAPACITY, 2'b00};
  localparam logic [ADDR_W-1:0] SPARE_ADDR = {~REG_CAPACITY, 2'b00};

  logic                clk_i   = 1'b0;
  logic                rst_ni  = 1'b0;
  logic                start   = 1'b0;
  logic                busy;
  logic                kind_i  = KIND_GET;
  logic [DATA_W-1:0]   key_i   = '0;
  logic [DATA_W-1:0]   value_i = '0;
  logic                done_o;
  logic                hit_o;
  logic [DATA_W-1:0]   read_value_o;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [ADDR_W-1:0]   paddr   = '0;
  logic [PDATA_W-1:0]  pwdata  = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  int                  outstanding;
  int                  fail_count;
  int unsigned         cycles = 0;
  logic [DATA_W-1:0]   key_pool [POOL_SIZE];
  int unsigned         phase_caps [10] = '{16, 1, 0, 31, 5, 2, 17, 8, 15, 16};

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  lru_key_value_cache_top #(.ENTRIES(ENTRIES)) uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .kind_i(kind_i), .key_i(key_i), .value_i(value_i),
    .done_o(done_o), .hit_o(hit_o), .read_value_o(read_value_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  lru_key_value_cache_checker #(.ENTRIES(ENTRIES)) u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start), .busy_i(busy),
    .kind_i(kind_i), .key_i(key_i), .value_i(value_i),
    .done_i(done_o), .hit_i(hit_o), .read_value_i(read_value_o),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .prdata_i(prdata), .pready_i(pready),
    .outstanding_o(outstanding), .fail_count_o(fail_count)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // returns at the edge that takes the item; start stays high
  task automatic send_item(kind_e op, logic [DATA_W-1:0] key, logic [DATA_W-1:0] value,
                           int unsigned gap, bit drain);
    if (drain || gap != 0) start <= 1'b0;
    if (drain) begin
      do @(posedge clk_i); while (outstanding != 0);
    end
    repeat (gap) @(posedge clk_i);
    kind_i  <= op;
    key_i   <= key;
    value_i <= value;
    start   <= 1'b1;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic apb_access(logic [ADDR_W-1:0] addr, logic [PDATA_W-1:0] data, bit wr);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic quiesce();
    start <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0 || busy);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] cap);
    logic [PDATA_W-1:0] data;
    quiesce();
    data = $urandom;
    data[CAP_W-1:0] = cap;
    apb_access(CAP_ADDR, data, 1'b1);
    apb_access(CAP_ADDR, '0, 1'b0);
  endtask

  initial begin
    int unsigned eff;
    int unsigned span;
    kind_e       op;
    logic [DATA_W-1:0] key;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty miss, extreme keys and values, update, eviction
    send_item(KIND_GET, '0, $urandom, 0, 1'b0);
    send_item(KIND_PUT, KEY_MIN, KEY_MAX, $urandom_range(0, 3), 1'b0);
    send_item(KIND_PUT, KEY_MAX, KEY_MIN, 0, 1'b0);
    send_item(KIND_GET, KEY_MIN, '0, $urandom_range(0, 3), 1'b0);
    send_item(KIND_GET, KEY_MAX, '1, 0, 1'b0);
    send_item(KIND_PUT, KEY_MAX, '1, 0, 1'b0);
    send_item(KIND_GET, KEY_MAX, $urandom, $urandom_range(0, 3), 1'b0);
    send_item(KIND_PUT, '1, '0, 0, 1'b0);
    send_item(KIND_GET, '1, $urandom, 0, 1'b0);
    send_item(KIND_GET, 32'd5, $urandom, 0, 1'b0);

    set_capacity(5'd3);
    send_item(KIND_PUT, 32'd1, $urandom, 0, 1'b0);
    send_item(KIND_PUT, 32'd2, $urandom, 0, 1'b0);
    send_item(KIND_PUT, 32'd3, $urandom, $urandom_range(0, 3), 1'b0);
    send_item(KIND_GET, 32'd1, $urandom, 0, 1'b0);
    send_item(KIND_PUT, 32'd4, $urandom, 0, 1'b0);
    send_item(KIND_GET, 32'd2, $urandom, 0, 1'b0);
    send_item(KIND_GET, 32'd1, $urandom, 0, 1'b0);

    // capacity lowered below the fill: only a new key's put evicts
    set_capacity(5'd1);
    apb_access(SPARE_ADDR, '0, 1'b1);
    apb_access(CAP_ADDR, '0, 1'b0);
    send_item(KIND_GET, 32'd4, $urandom, 0, 1'b0);
    send_item(KIND_PUT, 32'd4, $urandom, 0, 1'b0);
    send_item(KIND_PUT, 32'd9, $urandom, 0, 1'b0);
    send_item(KIND_GET, 32'd1, $urandom, 0, 1'b0);
    send_item(KIND_GET, 32'd9, $urandom, 0, 1'b0);

    foreach (phase_caps[p]) begin
      set_capacity(phase_caps[p][CAP_W-1:0]);
      eff  = (phase_caps[p] == 0) ? 1 : ((phase_caps[p] > ENTRIES) ? ENTRIES : phase_caps[p]);
      span = (eff + 4 < POOL_SIZE) ? eff + 4 : POOL_SIZE - 1;
      foreach (key_pool[i]) key_pool[i] = $urandom;
      key_pool[0] = KEY_MIN;
      key_pool[1] = KEY_MAX;
      key_pool[2] = '0;
      key_pool[3] = '1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        op  = ($urandom_range(0, 99) < 55) ? KIND_PUT : KIND_GET;
        key = ($urandom_range(0, 99) < 88) ? key_pool[$urandom_range(0, span)] : $urandom;
        send_item(op, key, $urandom, (p % 2 == 0) ? $urandom_range(0, 3) : 0,
                  $urandom_range(0, 63) == 0);
      end
    end

    start <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ lru_key_value_cache_top.f @@
rtl/core/lkvc_pkg.sv
rtl/core/lkvc_ram.sv
rtl/core/lru_key_value_cache_top.sv
rtl/core/lkvc_checker.sv
tb/lru_key_value_cache_checker.sv
tb/tb_lru_key_value_cache_top.sv
